// ===== hdl/l4hfe_pkg.sv =====
package l4hfe_pkg;

    // IP version codes
    localparam logic [3:0] C_VER_IPV4 = 4'd4;
    localparam logic [3:0] C_VER_IPV6 = 4'd6;

    // transport protocol codes
    localparam logic [7:0] C_PROTO_TCP = 8'd6;
    localparam logic [7:0] C_PROTO_UDP = 8'd17;

    // fixed header lengths
    localparam logic [5:0] C_IPV6_HDR_LEN = 6'd40;
    localparam logic [6:0] C_UDP_HDR_LEN  = 7'd8;

    // byte positions within the layer-3 header
    localparam logic [6:0] C_POS_MAX      = 7'd127;
    localparam logic [6:0] C_POS_PROTO_V4 = 7'd9;
    localparam logic [6:0] C_POS_PROTO_V6 = 7'd6;
    localparam logic [6:0] C_POS_SRC_LO   = 7'd12;
    localparam logic [6:0] C_POS_SRC_HI   = 7'd15;
    localparam logic [6:0] C_POS_DST_LO   = 7'd16;
    localparam logic [6:0] C_POS_DST_HI   = 7'd19;

    // byte offsets within the layer-4 header
    localparam logic [6:0] C_L4_PORT_HI = 7'd2;
    localparam logic [6:0] C_L4_PORT_LO = 7'd3;
    localparam logic [6:0] C_L4_ULEN_HI = 7'd4;
    localparam logic [6:0] C_L4_ULEN_LO = 7'd5;
    localparam logic [6:0] C_L4_TCP_OFF = 7'd12;

    // last position each header needs for a complete result
    localparam logic [6:0] C_NEED_V4      = 7'd19;
    localparam logic [6:0] C_NEED_V6      = 7'd6;
    localparam logic [6:0] C_NEED_TCP_REL = 7'd12;
    localparam logic [6:0] C_NEED_UDP_REL = 7'd5;

endpackage

// ===== hdl/ip_l4_header_field_extractor_unit.sv =====
// Layer-3/layer-4 header field extractor. Packet bytes enter one word per
// cycle, starting at byte 0 of the IPv4 or IPv6 header, with i_last_byte on
// the final byte. Each byte is captured by its position in one pass between
// the input register and the field state, so the sustained rate is one byte
// per clock; the result for a packet is loaded into the output register when
// its last byte leaves the input register. The input stalls only when a last
// byte is waiting behind a result that the downstream side has not yet taken.
// IPv6 addresses and extension headers are not parsed; an unknown version
// reports zero lengths and counts as complete.
module ip_l4_header_field_extractor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_net_version,
    output logic [5:0]  o_network_header_length,
    output logic [7:0]  o_transport_protocol,
    output logic [6:0]  o_total_header_length,
    output logic [15:0] o_destination_port,
    output logic [15:0] o_udp_payload_length,
    output logic [31:0] o_ipv4_source,
    output logic [31:0] o_ipv4_destination,
    output logic        o_fields_complete
);
    import l4hfe_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;

    // per-packet field state
    logic [6:0]  r_pos,  n_pos;
    logic [3:0]  r_ver,  n_ver;
    logic [5:0]  r_l3,   n_l3;
    logic [7:0]  r_prot, n_prot;
    logic [3:0]  r_toff, n_toff;
    logic [15:0] r_port, n_port;
    logic [15:0] r_ulen, n_ulen;
    logic [31:0] r_src,  n_src;
    logic [31:0] r_dst,  n_dst;

    // output register
    logic        r_out_valid;
    logic [3:0]  r_o_ver;
    logic [5:0]  r_o_l3;
    logic [7:0]  r_o_prot;
    logic [6:0]  r_o_total;
    logic [15:0] r_o_port;
    logic [15:0] r_o_ulen;
    logic [31:0] r_o_src;
    logic [31:0] r_o_dst;
    logic        r_o_cmpl;

    logic       adv;
    logic       proc;
    logic       in_load;
    logic [6:0] rel;

    // result fields
    logic       v4, v6, tcp, udp;
    logic [7:0] res_prot;
    logic [6:0] res_total;
    logic [6:0] need;
    logic [6:0] l3_ext;

    // a non-last word never needs the output register
    assign adv     = !r_in_last || !r_out_valid || !i_stall;
    assign proc    = r_in_valid && adv;
    assign in_load = !r_in_valid || adv;
    assign o_stall = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // capture by position
    assign rel = r_pos - {1'b0, r_l3};

    always_comb begin
        n_pos  = r_pos;
        n_ver  = r_ver;
        n_l3   = r_l3;
        n_prot = r_prot;
        n_toff = r_toff;
        n_port = r_port;
        n_ulen = r_ulen;
        n_src  = r_src;
        n_dst  = r_dst;
        if (proc) begin
            n_pos = (r_pos == C_POS_MAX) ? r_pos : r_pos + 7'd1;
            if (r_pos == 7'd0) begin
                n_ver = r_in_data[7:4];
                if (r_in_data[7:4] == C_VER_IPV4) begin
                    n_l3 = {r_in_data[3:0], 2'b00};
                end else if (r_in_data[7:4] == C_VER_IPV6) begin
                    n_l3 = C_IPV6_HDR_LEN;
                end else begin
                    n_l3 = 6'd0;
                end
            end else begin
                if ((r_pos == C_POS_PROTO_V4 && r_ver == C_VER_IPV4) ||
                    (r_pos == C_POS_PROTO_V6 && r_ver == C_VER_IPV6)) begin
                    n_prot = r_in_data;
                end
                if (r_pos >= C_POS_SRC_LO && r_pos <= C_POS_SRC_HI) begin
                    n_src = {r_src[23:0], r_in_data};
                end
                if (r_pos >= C_POS_DST_LO && r_pos <= C_POS_DST_HI) begin
                    n_dst = {r_dst[23:0], r_in_data};
                end
                // layer-4 fields, counted from the layer-3 length
                if (r_pos >= {1'b0, r_l3}) begin
                    case (rel) inside
                        C_L4_PORT_HI, C_L4_PORT_LO: begin
                            n_port = {r_port[7:0], r_in_data};
                        end
                        C_L4_ULEN_HI, C_L4_ULEN_LO: begin
                            n_ulen = {r_ulen[7:0], r_in_data};
                        end
                        C_L4_TCP_OFF: begin
                            n_toff = r_in_data[7:4];
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // field state clears after each last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc && r_in_last)) begin
            r_pos  <= '0;
            r_ver  <= '0;
            r_l3   <= '0;
            r_prot <= '0;
            r_toff <= '0;
            r_port <= '0;
            r_ulen <= '0;
            r_src  <= '0;
            r_dst  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_ver  <= n_ver;
            r_l3   <= n_l3;
            r_prot <= n_prot;
            r_toff <= n_toff;
            r_port <= n_port;
            r_ulen <= n_ulen;
            r_src  <= n_src;
            r_dst  <= n_dst;
        end
    end

    // result from the state including the last word
    assign l3_ext = {1'b0, n_l3};

    always_comb begin
        v4        = (n_ver == C_VER_IPV4);
        v6        = (n_ver == C_VER_IPV6);
        res_prot  = (v4 || v6) ? n_prot : 8'd0;
        tcp       = (res_prot == C_PROTO_TCP);
        udp       = (res_prot == C_PROTO_UDP);
        res_total = l3_ext;
        need      = 7'd0;
        if (v4) begin
            need = C_NEED_V4;
        end else if (v6) begin
            need = C_NEED_V6;
        end
        if (tcp) begin
            res_total = l3_ext + {1'b0, n_toff, 2'b00};
            if (l3_ext + C_NEED_TCP_REL > need) begin
                need = l3_ext + C_NEED_TCP_REL;
            end
        end else if (udp) begin
            res_total = l3_ext + C_UDP_HDR_LEN;
            if (l3_ext + C_NEED_UDP_REL > need) begin
                need = l3_ext + C_NEED_UDP_REL;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_o_ver   <= n_ver;
            r_o_l3    <= n_l3;
            r_o_prot  <= res_prot;
            r_o_total <= res_total;
            r_o_port  <= (tcp || udp) ? n_port : 16'd0;
            r_o_ulen  <= udp ? (n_ulen - {9'd0, C_UDP_HDR_LEN}) : 16'd0;
            r_o_src   <= v4 ? n_src : 32'd0;
            r_o_dst   <= v4 ? n_dst : 32'd0;
            r_o_cmpl  <= (r_pos >= need);
        end
    end

    assign o_valid                 = r_out_valid;
    assign o_net_version           = r_o_ver;
    assign o_network_header_length = r_o_l3;
    assign o_transport_protocol    = r_o_prot;
    assign o_total_header_length   = r_o_total;
    assign o_destination_port      = r_o_port;
    assign o_udp_payload_length    = r_o_ulen;
    assign o_ipv4_source           = r_o_src;
    assign o_ipv4_destination      = r_o_dst;
    assign o_fields_complete       = r_o_cmpl;

endmodule

// ===== hdl/l4hfe_checker.sv =====
module l4hfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [3:0]  o_net_version,
    input logic [5:0]  o_network_header_length,
    input logic [7:0]  o_transport_protocol,
    input logic [15:0] o_udp_payload_length,
    input logic [31:0] o_ipv4_source,
    input logic [31:0] o_ipv4_destination,
    input logic        o_fields_complete
);
    import l4hfe_pkg::*;

    // a stalled result word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ipv4_source))
        else $error("result dropped or changed under stall");

    // addresses only for IPv4
    a_addr_v4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_net_version != C_VER_IPV4 |->
            o_ipv4_source == 32'd0 && o_ipv4_destination == 32'd0)
        else $error("IPv4 address on a non-IPv4 result");

    // unknown version reports nothing and counts as complete
    a_unknown_ver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_net_version != C_VER_IPV4 && o_net_version != C_VER_IPV6 |->
            o_fields_complete && o_network_header_length == 6'd0 &&
            o_transport_protocol == 8'd0)
        else $error("unknown version result not empty");

    // UDP length only for UDP
    a_udp_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_transport_protocol != C_PROTO_UDP |->
            o_udp_payload_length == 16'd0)
        else $error("UDP payload length on a non-UDP result");

endmodule

bind ip_l4_header_field_extractor_unit l4hfe_checker u_l4hfe_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .o_valid                 (o_valid),
    .i_stall                 (i_stall),
    .o_net_version           (o_net_version),
    .o_network_header_length (o_network_header_length),
    .o_transport_protocol    (o_transport_protocol),
    .o_udp_payload_length    (o_udp_payload_length),
    .o_ipv4_source           (o_ipv4_source),
    .o_ipv4_destination      (o_ipv4_destination),
    .o_fields_complete       (o_fields_complete)
);
